[rtl/core/skt_pkg.sv]
package skt_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_KEY_BITS    = 16;
    localparam int DEF_HANDLE_BITS = 16;
    localparam int DEF_COUNT_BITS  = $clog2(DEF_CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
    } cmd_t;

endpackage

[rtl/core/skt_if.sv]
interface skt_req_if #(
    parameter int KEY_BITS    = skt_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = skt_pkg::DEF_HANDLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             op;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface skt_rsp_if #(
    parameter int HANDLE_BITS = skt_pkg::DEF_HANDLE_BITS,
    parameter int COUNT_BITS  = skt_pkg::DEF_COUNT_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [HANDLE_BITS-1:0] found_payload;
    logic [COUNT_BITS-1:0]  entry_count;
    logic                   is_empty;
    logic                   rejected;

    modport source (output valid, output found, output found_payload, output entry_count,
                    output is_empty, output rejected, input ready);
    modport sink   (input valid, input found, input found_payload, input entry_count,
                    input is_empty, input rejected, output ready);
endinterface

[rtl/core/skt_ctrl.sv]
module skt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output skt_pkg::cmd_t cmd
);

    skt_pkg::state_t state_reg, state_next;
    logic            rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            skt_pkg::ST_IDLE:
            begin
                // A new beat is taken once the result slot is free or draining.
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_valid && req_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = skt_pkg::ST_COMPARE;
                end
            end
            skt_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = skt_pkg::ST_APPLY;
            end
            skt_pkg::ST_APPLY:
            begin
                cmd.apply      = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = skt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/core/skt_datapath.sv]
module skt_datapath #(
    parameter int CAPACITY    = skt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS    = skt_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = skt_pkg::DEF_HANDLE_BITS,
    parameter int COUNT_BITS  = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skt_pkg::cmd_t          cmd,
    input  logic [1:0]             op,
    input  logic [KEY_BITS-1:0]    key,
    input  logic [HANDLE_BITS-1:0] payload,
    output logic                   found,
    output logic [HANDLE_BITS-1:0] found_payload,
    output logic [COUNT_BITS-1:0]  entry_count,
    output logic                   is_empty,
    output logic                   rejected
);

    skt_pkg::op_t           op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic [KEY_BITS-1:0]    keys_reg [CAPACITY];
    logic [HANDLE_BITS-1:0] pays_reg [CAPACITY];
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    // ge marks live cells whose key is not smaller than the request key; since
    // the row is sorted this is a thermometer that starts at the insert point.
    logic [CAPACITY-1:0] ge_reg, eq_reg;
    logic [CAPACITY-1:0] sel, sel_prev, ge_prev, first;

    logic                   found_reg, rejected_reg;
    logic [HANDLE_BITS-1:0] found_payload_reg, lookup_payload;

    logic is_full, hit, do_insert, do_remove;

    assign is_full   = count_reg == COUNT_BITS'(CAPACITY);
    assign hit       = |eq_reg;
    assign do_insert = cmd.apply && op_reg == skt_pkg::OP_INSERT && !is_full;
    assign do_remove = cmd.apply && op_reg == skt_pkg::OP_REMOVE && hit;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= skt_pkg::op_t'(op);
            key_reg    <= key;
            handle_reg <= payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ge_reg[i] <= (COUNT_BITS'(i) < count_reg) && (keys_reg[i] >= key_reg);
                eq_reg[i] <= (COUNT_BITS'(i) < count_reg) && (keys_reg[i] == key_reg);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel[i] = ge_reg[i] || (COUNT_BITS'(i) == count_reg);
        end
    end

    assign sel_prev = {sel[CAPACITY-2:0], 1'b0};
    assign ge_prev  = {ge_reg[CAPACITY-2:0], 1'b0};
    assign first    = eq_reg & ~ge_prev;

    always_comb
    begin
        lookup_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            lookup_payload = lookup_payload | (first[i] ? pays_reg[i] : '0);
        end
    end

    // Each cell loads from its left neighbor, its right neighbor or the request.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [KEY_BITS-1:0]    left_key, right_key;
        logic [HANDLE_BITS-1:0] left_pay, right_pay;

        if (g == 0)
        begin : g_first
            assign left_key = key_reg;
            assign left_pay = handle_reg;
        end
        else
        begin : g_rest
            assign left_key = keys_reg[g-1];
            assign left_pay = pays_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_key = keys_reg[g];
            assign right_pay = pays_reg[g];
        end
        else
        begin : g_inner
            assign right_key = keys_reg[g+1];
            assign right_pay = pays_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_insert && sel[g])
            begin
                keys_reg[g] <= sel_prev[g] ? left_key : key_reg;
                pays_reg[g] <= sel_prev[g] ? left_pay : handle_reg;
            end
            else if (do_remove && ge_reg[g])
            begin
                keys_reg[g] <= right_key;
                pays_reg[g] <= right_pay;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.apply)
        begin
            case (op_reg)
                skt_pkg::OP_INSERT: if (!is_full) count_next = count_reg + 1'b1;
                skt_pkg::OP_REMOVE: if (hit) count_next = count_reg - 1'b1;
                skt_pkg::OP_CLEAR:  count_next = '0;
                default:            count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            found_reg         <= hit && (op_reg == skt_pkg::OP_REMOVE ||
                                         op_reg == skt_pkg::OP_LOOKUP);
            found_payload_reg <= (op_reg == skt_pkg::OP_LOOKUP) ? lookup_payload : '0;
            rejected_reg      <= (op_reg == skt_pkg::OP_INSERT) && is_full;
        end
    end

    assign found         = found_reg;
    assign found_payload = found_payload_reg;
    assign entry_count   = count_reg;
    assign is_empty      = count_reg == '0;
    assign rejected      = rejected_reg;

endmodule

[rtl/core/sorted_key_table.sv]
// A request beat is accepted only in the idle state and while the result slot is free or draining;
// each operation then steps through accept, compare row and update row, and the next beat waits for it.
// The row of cells compares all entries at once, so this sequence does not depend on the count.
// Reset (rst_n, asynchronous, active low) empties the table and drops any pending result;
// entry contents are not cleared and are never read until written.
module sorted_key_table #(
    parameter int CAPACITY    = skt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS    = skt_pkg::DEF_KEY_BITS,
    parameter int HANDLE_BITS = skt_pkg::DEF_HANDLE_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    skt_req_if.sink  req,
    skt_rsp_if.source rsp
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    skt_pkg::cmd_t cmd;

    // The controller sequences each request beat through a compare cycle,
    // where every live cell checks its key against the request, and an apply
    // cycle, where the row shifts in place and the result is registered.
    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // The datapath holds the sorted row of cells, the entry count and the
    // result register that waits for the downstream side.
    skt_datapath #(
        .CAPACITY    (CAPACITY),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (req.op),
        .key           (req.key),
        .payload       (req.payload),
        .found         (rsp.found),
        .found_payload (rsp.found_payload),
        .entry_count   (rsp.entry_count),
        .is_empty      (rsp.is_empty),
        .rejected      (rsp.rejected)
    );

endmodule
